[design/bounding_sphere_merge_defines.svh]
// assertion macros shared by the sphere merge rtl
// no dependencies; included by the files that carry assertions
`ifndef BOUNDING_SPHERE_MERGE_DEFINES_SVH
`define BOUNDING_SPHERE_MERGE_DEFINES_SVH

`ifndef SYNTH
// checked only while reset is released
`define BSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/bsm_pkg.sv]
// widths, constants and sideband types of the sphere merge pipeline
// no dependencies
`default_nettype none
package bsm_pkg;

    localparam int CW      = 32;          // center width
    localparam int RW      = 31;          // radius width
    localparam int MW      = CW + 1;      // center difference magnitude
    localparam int SW      = 2 * MW;      // sum of squares
    localparam int SQ_BITS = 33;          // root bits
    localparam int KW      = SQ_BITS + 1; // |d + r2 - r1|
    localparam int PW      = MW + KW;     // offset numerator
    localparam int DV_BITS = 34;          // quotient bits
    localparam int DW      = SQ_BITS + 1; // divisor 2d
    localparam int RADW    = SQ_BITS;     // unclamped radius
    localparam int XW      = CW + 3;      // center before clamp

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         sgn;
        logic [2:0][CW-1:0] c1;
        logic [RW-1:0]      r1;
        logic [RW-1:0]      r2;
        logic               coin;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]         neg;
        logic [2:0][CW-1:0] c1;
        logic [RADW-1:0]    rad;
        logic               coin;
    } t_dv_side;

endpackage
`default_nettype wire

[design/bsm_sqrt.sv]
// pipelined floor square root, one root bit per register stage
// depends on bsm_pkg
`default_nettype none
module bsm_sqrt import bsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [SW-1:0]      i_rad,
    input  t_sq_side           i_side,
    output logic               o_vld,
    output logic [SQ_BITS-1:0] o_root,
    output t_sq_side           o_side
);

    logic               r_vld  [0:SQ_BITS-1];
    logic [SW-1:0]      r_rem  [0:SQ_BITS-1];
    logic [SQ_BITS-1:0] r_root [0:SQ_BITS-1];
    t_sq_side           r_side [0:SQ_BITS-1];

    logic               p_vld  [0:SQ_BITS-1];
    logic [SW-1:0]      p_rem  [0:SQ_BITS-1];
    logic [SQ_BITS-1:0] p_root [0:SQ_BITS-1];
    t_sq_side           p_side [0:SQ_BITS-1];
    logic [SW-1:0]      trial  [0:SQ_BITS-1];
    logic [SW-1:0]      n_rem  [0:SQ_BITS-1];
    logic [SQ_BITS-1:0] n_root [0:SQ_BITS-1];

    always_comb begin
        p_vld[0]  = i_vld;
        p_rem[0]  = i_rad;
        p_root[0] = '0;
        p_side[0] = i_side;
        for (int s = 1; s < SQ_BITS; s++) begin
            p_vld[s]  = r_vld[s-1];
            p_rem[s]  = r_rem[s-1];
            p_root[s] = r_root[s-1];
            p_side[s] = r_side[s-1];
        end
        for (int s = 0; s < SQ_BITS; s++) begin
            // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
            trial[s] = ({{(SW-SQ_BITS){1'b0}}, p_root[s]} << (SQ_BITS - s))
                     | (SW'(1) << (2 * (SQ_BITS - 1 - s)));
            n_rem[s]  = p_rem[s];
            n_root[s] = p_root[s];
            if (p_rem[s] >= trial[s]) begin
                n_rem[s]  = p_rem[s] - trial[s];
                n_root[s] = p_root[s] | (SQ_BITS'(1) << (SQ_BITS - 1 - s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQ_BITS; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld[s];
            end
            if (i_en) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_side[s] <= p_side[s];
            end
        end
    end

    assign o_vld  = r_vld[SQ_BITS-1];
    assign o_root = r_root[SQ_BITS-1];
    assign o_side = r_side[SQ_BITS-1];

endmodule
`default_nettype wire

[design/bsm_div.sv]
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
// depends on bsm_pkg
`default_nettype none
module bsm_div import bsm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [2:0][PW-1:0]      i_num,
    input  logic [DW-1:0]           i_den,
    input  t_dv_side                i_side,
    output logic                    o_vld,
    output logic [2:0][DV_BITS-1:0] o_quo,
    output t_dv_side                o_side
);

    logic                    r_vld  [0:DV_BITS-1];
    logic [2:0][DW-1:0]      r_rem  [0:DV_BITS-1];
    logic [2:0][DV_BITS-1:0] r_quo  [0:DV_BITS-1];
    logic [2:0][PW-1:0]      r_num  [0:DV_BITS-1];
    logic [DW-1:0]           r_den  [0:DV_BITS-1];
    t_dv_side                r_side [0:DV_BITS-1];

    logic                    p_vld  [0:DV_BITS-1];
    logic [2:0][DW-1:0]      p_rem  [0:DV_BITS-1];
    logic [2:0][DV_BITS-1:0] p_quo  [0:DV_BITS-1];
    logic [2:0][PW-1:0]      p_num  [0:DV_BITS-1];
    logic [DW-1:0]           p_den  [0:DV_BITS-1];
    t_dv_side                p_side [0:DV_BITS-1];
    logic [2:0][DW:0]        trial  [0:DV_BITS-1];
    logic [2:0][DW-1:0]      n_rem  [0:DV_BITS-1];
    logic [2:0][DV_BITS-1:0] n_quo  [0:DV_BITS-1];

    always_comb begin
        p_vld[0]  = i_vld;
        p_num[0]  = i_num;
        p_den[0]  = i_den;
        p_side[0] = i_side;
        p_quo[0]  = '0;
        // quotient fits in DV_BITS, so the top part is already below the divisor
        for (int l = 0; l < 3; l++) begin
            p_rem[0][l] = DW'(i_num[l][PW-1:DV_BITS]);
        end
        for (int s = 1; s < DV_BITS; s++) begin
            p_vld[s]  = r_vld[s-1];
            p_rem[s]  = r_rem[s-1];
            p_quo[s]  = r_quo[s-1];
            p_num[s]  = r_num[s-1];
            p_den[s]  = r_den[s-1];
            p_side[s] = r_side[s-1];
        end
        for (int s = 0; s < DV_BITS; s++) begin
            for (int l = 0; l < 3; l++) begin
                trial[s][l] = {p_rem[s][l], p_num[s][l][DV_BITS-1-s]};
                if (trial[s][l] >= {1'b0, p_den[s]}) begin
                    n_rem[s][l] = DW'(trial[s][l] - {1'b0, p_den[s]});
                    n_quo[s][l] = {p_quo[s][l][DV_BITS-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = trial[s][l][DW-1:0];
                    n_quo[s][l] = {p_quo[s][l][DV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DV_BITS; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld[s];
            end
            if (i_en) begin
                r_rem[s]  <= n_rem[s];
                r_quo[s]  <= n_quo[s];
                r_num[s]  <= p_num[s];
                r_den[s]  <= p_den[s];
                r_side[s] <= p_side[s];
            end
        end
    end

    assign o_vld  = r_vld[DV_BITS-1];
    assign o_quo  = r_quo[DV_BITS-1];
    assign o_side = r_side[DV_BITS-1];

endmodule
`default_nettype wire

[design/bounding_sphere_merge.sv]
// Merges two spheres into the enclosing sphere centered on the line between
// their centers. Fully pipelined: one sphere pair may enter every cycle that
// o_stall is low, and passes through 73 register stages (three front stages,
// 33 square root stages, two stages forming the offset numerator, 34 divider
// stages and the output register). A stall on the output freezes the whole
// pipeline, so nothing is lost or repeated. Equal centers give center c1,
// radius (r1+r2)/2 and raise centers_coincide; clamped results raise saturated.
// depends on bsm_pkg, bsm_sqrt, bsm_div and bounding_sphere_merge_defines.svh
`default_nettype none
`include "bounding_sphere_merge_defines.svh"
module bounding_sphere_merge import bsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_first_center_x,
    input  logic signed [CW-1:0] i_first_center_y,
    input  logic signed [CW-1:0] i_first_center_z,
    input  logic [RW-1:0]        i_first_radius,
    input  logic signed [CW-1:0] i_second_center_x,
    input  logic signed [CW-1:0] i_second_center_y,
    input  logic signed [CW-1:0] i_second_center_z,
    input  logic [RW-1:0]        i_second_radius,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [CW-1:0] o_merged_center_x,
    output logic signed [CW-1:0] o_merged_center_y,
    output logic signed [CW-1:0] o_merged_center_z,
    output logic [RW-1:0]        o_merged_radius,
    output logic                 o_centers_coincide,
    output logic                 o_saturated
);

    logic en;

    // stage 1: differences
    logic               r1_vld;
    logic [2:0][MW-1:0] r1_diff;
    logic [2:0][CW-1:0] r1_c1;
    logic [RW-1:0]      r1_r1, r1_r2;
    logic               r1_coin;
    logic [2:0][CW-1:0] c1_in, c2_in;
    logic [2:0][MW-1:0] n1_diff;

    // stage 2: squares
    logic               r2_vld;
    logic [2:0][SW-1:0] r2_sq;
    t_sq_side           r2_side;
    logic [2:0][MW-1:0] mag;
    t_sq_side           n2_side;

    // stage 3: sum of squares
    logic               r3_vld;
    logic [SW-1:0]      r3_s;
    t_sq_side           r3_side;

    logic               sq_vld;
    logic [SQ_BITS-1:0] sq_d;
    t_sq_side           sq_side;

    // stage 4: k = d + r2 - r1 and the radius
    logic               r4_vld;
    logic [KW-1:0]      r4_kmag;
    logic               r4_kneg;
    logic [SQ_BITS-1:0] r4_d;
    logic [RADW-1:0]    r4_rad;
    t_sq_side           r4_side;
    logic [KW:0]        k;
    logic [SQ_BITS:0]   rad_sum;

    // stage 5: offset numerators
    logic               r5_vld;
    logic [2:0][PW-1:0] r5_prod;
    logic [DW-1:0]      r5_den;
    t_dv_side           r5_side;
    t_dv_side           n5_side;

    logic                    dv_vld;
    logic [2:0][DV_BITS-1:0] dv_quo;
    t_dv_side                dv_side;

    // output register
    logic               r_out_vld;
    logic [2:0][CW-1:0] r_out_c;
    logic [RW-1:0]      r_out_rad;
    logic               r_out_coin;
    logic               r_out_sat;
    logic [2:0][XW-1:0] cx;
    logic [2:0][CW-1:0] n_out_c;
    logic [RW-1:0]      n_out_rad;
    logic               n_out_sat;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    always_comb begin
        c1_in = {i_first_center_z, i_first_center_y, i_first_center_x};
        c2_in = {i_second_center_z, i_second_center_y, i_second_center_x};
        for (int l = 0; l < 3; l++) begin
            n1_diff[l] = {c2_in[l][CW-1], c2_in[l]} - {c1_in[l][CW-1], c1_in[l]};
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            mag[l] = r1_diff[l][MW-1] ? MW'(~r1_diff[l] + 1'b1) : r1_diff[l];
        end
        n2_side.mag  = mag;
        n2_side.sgn  = {r1_diff[2][MW-1], r1_diff[1][MW-1], r1_diff[0][MW-1]};
        n2_side.c1   = r1_c1;
        n2_side.r1   = r1_r1;
        n2_side.r2   = r1_r2;
        n2_side.coin = r1_coin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (en) begin
            r1_diff <= n1_diff;
            r1_c1   <= c1_in;
            r1_r1   <= i_first_radius;
            r1_r2   <= i_second_radius;
            r1_coin <= (n1_diff == '0);
            for (int l = 0; l < 3; l++) begin
                r2_sq[l] <= {{(SW-MW){1'b0}}, mag[l]} * {{(SW-MW){1'b0}}, mag[l]};
            end
            r2_side <= n2_side;
            r3_s    <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_side <= r2_side;
        end
    end

    bsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_rad   (r3_s),
        .i_side  (r3_side),
        .o_vld   (sq_vld),
        .o_root  (sq_d),
        .o_side  (sq_side)
    );

    always_comb begin
        k = {2'b00, sq_d} + {{(KW+1-RW){1'b0}}, sq_side.r2}
          - {{(KW+1-RW){1'b0}}, sq_side.r1};
        rad_sum = {1'b0, sq_d} + {{(SQ_BITS+1-RW){1'b0}}, sq_side.r1}
                + {{(SQ_BITS+1-RW){1'b0}}, sq_side.r2};
        n5_side.neg  = r4_side.sgn ^ {3{r4_kneg}};
        n5_side.c1   = r4_side.c1;
        n5_side.rad  = r4_rad;
        n5_side.coin = r4_side.coin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= sq_vld;
            r5_vld <= r4_vld;
        end
        if (en) begin
            r4_kneg <= k[KW];
            r4_kmag <= k[KW] ? KW'(~k + 1'b1) : k[KW-1:0];
            r4_d    <= sq_d;
            r4_rad  <= rad_sum[SQ_BITS:1];
            r4_side <= sq_side;
            for (int l = 0; l < 3; l++) begin
                r5_prod[l] <= {{(PW-MW){1'b0}}, r4_side.mag[l]}
                            * {{(PW-KW){1'b0}}, r4_kmag};
            end
            r5_den  <= {r4_d, 1'b0};
            r5_side <= n5_side;
        end
    end

    bsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_num   (r5_prod),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_comb begin
        n_out_sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            if (dv_side.neg[l]) begin
                cx[l] = {{(XW-CW){dv_side.c1[l][CW-1]}}, dv_side.c1[l]}
                      - {{(XW-DV_BITS){1'b0}}, dv_quo[l]};
            end else begin
                cx[l] = {{(XW-CW){dv_side.c1[l][CW-1]}}, dv_side.c1[l]}
                      + {{(XW-DV_BITS){1'b0}}, dv_quo[l]};
            end
            // in range when the bits above the sign all match it
            if ((&cx[l][XW-1:CW-1]) || !(|cx[l][XW-1:CW-1])) begin
                n_out_c[l] = cx[l][CW-1:0];
            end else begin
                n_out_c[l] = {cx[l][XW-1], {(CW-1){!cx[l][XW-1]}}};
                n_out_sat  = 1'b1;
            end
        end
        if (|dv_side.rad[RADW-1:RW]) begin
            n_out_rad = {RW{1'b1}};
            n_out_sat = 1'b1;
        end else begin
            n_out_rad = dv_side.rad[RW-1:0];
        end
        // coincident centers: offset undefined, keep c1
        if (dv_side.coin) begin
            n_out_c   = dv_side.c1;
            n_out_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
        if (en) begin
            r_out_c    <= n_out_c;
            r_out_rad  <= n_out_rad;
            r_out_coin <= dv_side.coin;
            r_out_sat  <= n_out_sat;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_merged_center_x  = r_out_c[0];
    assign o_merged_center_y  = r_out_c[1];
    assign o_merged_center_z  = r_out_c[2];
    assign o_merged_radius    = r_out_rad;
    assign o_centers_coincide = r_out_coin;
    assign o_saturated        = r_out_sat;

    `BSM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `BSM_ASSERT(a_coin_nosat, i_clk, i_rst_n, o_valid && o_centers_coincide |-> !o_saturated, "coincident centers flagged saturated")
    `BSM_ASSERT(a_hold, i_clk, i_rst_n, r1_vld && o_stall |=> r1_vld, "front stage lost a beat under stall")

endmodule
`default_nettype wire
